[rtl/core/ptbs_pkg.sv]
// ---------------------------------------------------------------------------
// ptbs_pkg
// Shared constants, command codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ptbs_pkg;

	localparam int N_QUEUES_DEF    = 4;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int GAP_BITS_DEF    = 96;

	localparam logic [1:0] CMD_ENQ   = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;
	localparam logic [1:0] CMD_STATS = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BADQ = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [2:0] REG_QIU    = 3'd0;
	localparam logic [2:0] REG_PRIO   = 3'd1;
	localparam logic [2:0] REG_TLIMIT = 3'd2;
	localparam logic [2:0] REG_TOK0   = 3'd3;
	localparam logic [2:0] REG_TOK3   = 3'd6;

	typedef struct packed {
		logic start;    // latch input, begin command
		logic exec;     // apply enqueue / start round with latched input
		logic rd_head;  // issue memory read of head at scan queue
		logic eval;     // evaluate scan queue with read data
		logic finish;   // load result register
	} ptbs_cmd_t;

	typedef struct packed {
		logic step_more;   // step: continue scanning
		logic hit;         // step: scan queue sends its head
	} ptbs_stat_t;

endpackage

[rtl/core/ptbs_datapath.sv]
// ---------------------------------------------------------------------------
// ptbs_datapath
// Queue storage, buckets, wall time and statistics; executes one command.
// ---------------------------------------------------------------------------
module ptbs_datapath #(
	parameter int N_QUEUES    = ptbs_pkg::N_QUEUES_DEF,
	parameter int QUEUE_DEPTH = ptbs_pkg::QUEUE_DEPTH_DEF,
	parameter int GAP_BITS    = ptbs_pkg::GAP_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ptbs_pkg::ptbs_cmd_t cmd,
	output ptbs_pkg::ptbs_stat_t stat,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [47:0]         cfg_data,
	input  logic [1:0]          command,
	input  logic [1:0]          queue_index,
	input  logic [15:0]         packet_bytes,
	input  logic                out_take,
	output logic                out_full,
	output logic [1:0]          status,
	output logic                sent,
	output logic [1:0]          sent_queue,
	output logic [15:0]         sent_bytes,
	output logic                round_done,
	output logic [47:0]         wall_time,
	output logic [31:0]         stat_packets,
	output logic [47:0]         stat_bytes,
	output logic [4:0]          stat_depth
);
	localparam int QW = (N_QUEUES > 1) ? $clog2(N_QUEUES) : 1;
	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = $clog2(N_QUEUES + 1);
	localparam int AW = QW + SW;
	localparam logic [47:0] MAX48 = '1;
	localparam logic [31:0] MAX32 = '1;

	logic [2:0]  qiu_q;
	logic        prio_q;
	logic [47:0] tlim_q;
	logic [19:0] tok_q [4];

	logic [15:0]   mem [1 << AW];
	logic [15:0]   rdata_q;
	logic [SW-1:0] head_q [N_QUEUES];
	logic [CW-1:0] cnt_q  [N_QUEUES];
	logic [19:0]   bkt_q  [N_QUEUES];
	logic [31:0]   pk_q   [N_QUEUES];
	logic [47:0]   by_q   [N_QUEUES];
	logic [PW-1:0] scan_q;
	logic          act_q;
	logic [47:0]   time_q;

	logic [1:0]  c_cmd_q;
	logic [1:0]  c_qi_q;
	logic [15:0] c_len_q;

	logic [PW-1:0] nq;
	always_comb begin
		if (qiu_q == 3'd0) nq = PW'(1);
		else if (32'(qiu_q) > N_QUEUES) nq = PW'(N_QUEUES);
		else nq = PW'(qiu_q);
	end

	logic          qi_ok;
	logic [QW-1:0] qi;
	assign qi_ok = 32'(c_qi_q) < 32'(nq);
	assign qi    = QW'(c_qi_q);

	// scan queue for step
	logic [QW-1:0] sq;
	logic          in_prio;
	logic          scan_ok;
	assign in_prio = prio_q && scan_q == '0;
	assign scan_ok = scan_q < nq;
	assign sq      = QW'(scan_q);

	logic q_has;
	assign q_has = cnt_q[sq] != '0;

	logic fits;
	assign fits = in_prio || ({4'd0, rdata_q} <= bkt_q[sq]);

	logic sent_now;
	assign sent_now = cmd.eval && act_q && scan_ok && q_has && fits;

	always_comb begin
		stat.step_more = act_q && scan_ok;
		stat.hit       = act_q && scan_ok && q_has && fits;
	end

	logic [48:0] t_sum;
	logic [47:0] t_new;
	logic [48:0] b_sum;
	assign t_sum = {1'b0, time_q} + {30'd0, rdata_q, 3'd0} + 49'(GAP_BITS);
	assign t_new = t_sum[48] ? MAX48 : t_sum[47:0];
	assign b_sum = {1'b0, by_q[sq]} + {33'd0, rdata_q};

	logic [SW:0]   wsum;
	logic [SW-1:0] wslot;
	assign wsum  = (SW+1)'(head_q[qi]) + (SW+1)'(cnt_q[qi]);
	assign wslot = (32'(wsum) >= QUEUE_DEPTH) ? SW'(wsum - (SW+1)'(QUEUE_DEPTH)) : SW'(wsum);

	logic [SW-1:0] head_nxt;
	assign head_nxt = (32'(head_q[sq]) == QUEUE_DEPTH - 1) ? '0 : head_q[sq] + SW'(1);

	always_ff @(posedge clk) begin
		if (cmd.exec && c_cmd_q == ptbs_pkg::CMD_ENQ && qi_ok
				&& 32'(cnt_q[qi]) < QUEUE_DEPTH)
			mem[AW'({qi, wslot})] <= c_len_q;
		if (cmd.rd_head)
			rdata_q <= mem[AW'({sq, head_q[sq]})];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qiu_q  <= 3'd4;
			prio_q <= 1'b0;
			tlim_q <= MAX48;
			for (int i = 0; i < 4; i++) tok_q[i] <= 20'd12000;
			for (int i = 0; i < N_QUEUES; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
				bkt_q[i]  <= '0;
				pk_q[i]   <= '0;
				by_q[i]   <= '0;
			end
			scan_q   <= '0;
			act_q    <= 1'b0;
			time_q   <= '0;
			out_full <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					ptbs_pkg::REG_QIU:    qiu_q  <= cfg_data[2:0];
					ptbs_pkg::REG_PRIO:   prio_q <= cfg_data[0];
					ptbs_pkg::REG_TLIMIT: tlim_q <= cfg_data;
					default: begin
						if (cfg_idx >= ptbs_pkg::REG_TOK0 && cfg_idx <= ptbs_pkg::REG_TOK3)
							tok_q[2'(cfg_idx - ptbs_pkg::REG_TOK0)] <= cfg_data[19:0];
					end
				endcase
			end
			if (cmd.exec) begin
				case (c_cmd_q)
					ptbs_pkg::CMD_ENQ: begin
						if (qi_ok && 32'(cnt_q[qi]) < QUEUE_DEPTH)
							cnt_q[qi] <= cnt_q[qi] + CW'(1);
					end
					ptbs_pkg::CMD_START: begin
						for (int i = 0; i < N_QUEUES; i++)
							if (i < 32'(nq)) bkt_q[i] <= (i < 4) ? tok_q[i % 4] : 20'd0;
						scan_q <= '0;
						act_q  <= 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.eval && act_q) begin
				if (!scan_ok) act_q <= 1'b0;
				else if (q_has && fits) begin
					head_q[sq] <= head_nxt;
					cnt_q[sq]  <= cnt_q[sq] - CW'(1);
					if (!in_prio) bkt_q[sq] <= bkt_q[sq] - {4'd0, rdata_q};
					if (pk_q[sq] != MAX32) pk_q[sq] <= pk_q[sq] + 32'd1;
					by_q[sq] <= b_sum[48] ? MAX48 : b_sum[47:0];
					time_q   <= t_new;
					if (t_new > tlim_q) act_q <= 1'b0;
				end else begin
					scan_q <= scan_q + PW'(1);
				end
			end
			if (cmd.finish) out_full <= 1'b1;
			else if (out_take) out_full <= 1'b0;
		end
	end

	// full flag captured at start, since count changes after the write
	logic qi_ok_in;
	logic enq_full;
	assign qi_ok_in = 32'(queue_index) < 32'(nq);
	always_ff @(posedge clk) begin
		if (cmd.start)
			enq_full <= qi_ok_in && 32'(cnt_q[QW'(queue_index)]) >= QUEUE_DEPTH;
	end

	function automatic logic [1:0] ST_calc();
		logic [1:0] s;
		s = ptbs_pkg::ST_OK;
		if (c_cmd_q == ptbs_pkg::CMD_ENQ || c_cmd_q == ptbs_pkg::CMD_STATS) begin
			if (!qi_ok) s = ptbs_pkg::ST_BADQ;
			else if (c_cmd_q == ptbs_pkg::CMD_ENQ && enq_full) s = ptbs_pkg::ST_FULL;
		end
		return s;
	endfunction

	logic [1:0]  sent_q_q;
	logic [15:0] sent_b_q;
	logic        sent_f_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_f_q <= 1'b0;
		end else if (cmd.start) begin
			sent_f_q <= 1'b0;
		end else if (sent_now) begin
			sent_f_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			c_cmd_q  <= command;
			c_qi_q   <= queue_index;
			c_len_q  <= packet_bytes;
		end
		if (sent_now) begin
			sent_q_q <= 2'(sq);
			sent_b_q <= rdata_q;
		end
		if (cmd.finish) begin
			status       <= ST_calc();
			sent         <= sent_f_q;
			sent_queue   <= sent_f_q ? sent_q_q : 2'd0;
			sent_bytes   <= sent_f_q ? sent_b_q : 16'd0;
			round_done   <= !act_q;
			wall_time    <= time_q;
			stat_packets <= (c_cmd_q == ptbs_pkg::CMD_STATS && qi_ok) ? pk_q[qi] : '0;
			stat_bytes   <= (c_cmd_q == ptbs_pkg::CMD_STATS && qi_ok) ? by_q[qi] : '0;
			stat_depth   <= (c_cmd_q == ptbs_pkg::CMD_STATS && qi_ok) ? 5'(cnt_q[qi]) : '0;
		end
	end

endmodule

[rtl/core/ptbs_ctrl.sv]
// ---------------------------------------------------------------------------
// ptbs_ctrl
// Command sequencer: accept, scan read/evaluate loop, result hand-off.
// ---------------------------------------------------------------------------
module ptbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  ptbs_pkg::ptbs_stat_t stat,
	input  logic                 out_full,
	input  logic                 out_take,
	output ptbs_pkg::ptbs_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q;
	logic       is_step_q;
	logic       slot_free;

	assign slot_free = !out_full || out_take;
	assign in_ready  = state_q == S_IDLE;

	always_comb begin
		cmd         = '0;
		cmd.start   = in_valid && in_ready;
		cmd.exec    = state_q == S_DEC;
		cmd.rd_head = state_q == S_RD;
		cmd.eval    = state_q == S_EV;
		cmd.finish  = state_q == S_FIN && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			is_step_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					is_step_q <= command == ptbs_pkg::CMD_STEP;
					state_q   <= S_DEC;
				end
				S_DEC: state_q <= is_step_q ? S_RD : S_FIN;
				S_RD: state_q <= S_EV;
				S_EV: begin
					if (stat.step_more && !stat.hit) state_q <= S_RD;
					else state_q <= S_FIN;
				end
				S_FIN: if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/core/priority_token_bucket_scheduler_unit.sv]
// ---------------------------------------------------------------------------
// priority_token_bucket_scheduler_unit
// Strict-priority token-bucket packet scheduler, top level.
// ---------------------------------------------------------------------------
// Usage: one command transaction on in_* (enqueue, start round, service
// step, read stats) gives exactly one result transaction on out_*.
// Configuration registers are written through cfg_we/cfg_idx/cfg_data; the
// user must do so while the unit is idle, which the block does not enforce.
// Enqueue, start and stats pass from accept through the decode and final
// states to the result. A service step goes from decode into a loop of the
// read and evaluate states, checking one queue head at a time, until a head
// is sent or every queue in use is skipped (up to N_QUEUES), then to final.
// One command is in work at a time; the result sits in an output register,
// so a new command is taken while the previous result waits.
// If the receiver stalls with a result already held, the next command
// waits in its final state until the output register frees.
// Reset clears all queues, buckets, statistics and wall time and loads the
// register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
module priority_token_bucket_scheduler_unit #(
	parameter int N_QUEUES    = ptbs_pkg::N_QUEUES_DEF,
	parameter int QUEUE_DEPTH = ptbs_pkg::QUEUE_DEPTH_DEF,
	parameter int GAP_BITS    = ptbs_pkg::GAP_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [1:0]  queue_index,
	input  logic [15:0] packet_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        sent,
	output logic [1:0]  sent_queue,
	output logic [15:0] sent_bytes,
	output logic        round_done,
	output logic [47:0] wall_time,
	output logic [31:0] stat_packets,
	output logic [47:0] stat_bytes,
	output logic [4:0]  stat_depth
);
	ptbs_pkg::ptbs_cmd_t  cmd;
	ptbs_pkg::ptbs_stat_t stat;
	logic                 out_take;

	assign out_take = out_valid && out_ready;

	ptbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (stat),
		.out_full (out_valid),
		.out_take (out_take),
		.cmd      (cmd)
	);

	ptbs_datapath #(
		.N_QUEUES    (N_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.GAP_BITS    (GAP_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.command      (command),
		.queue_index  (queue_index),
		.packet_bytes (packet_bytes),
		.out_take     (out_take),
		.out_full     (out_valid),
		.status       (status),
		.sent         (sent),
		.sent_queue   (sent_queue),
		.sent_bytes   (sent_bytes),
		.round_done   (round_done),
		.wall_time    (wall_time),
		.stat_packets (stat_packets),
		.stat_bytes   (stat_bytes),
		.stat_depth   (stat_depth)
	);
endmodule
